// ===== design/ibrf_pkg.sv =====
package ibrf_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_PATCH   = 3'd0,
    ST_NOWRITE = 3'd1,
    ST_ILLEGAL = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_DROP    = 3'd4
  } status_t;

  // Write size codes.
  typedef enum logic [1:0] {
    SZ_NONE = 2'd0,
    SZ_2B   = 2'd1,
    SZ_4B   = 2'd2,
    SZ_8B   = 2'd3
  } size_t;

  // Relocation type codes carried in entry bits 15..12.
  typedef enum logic [3:0] {
    RT_ABSOLUTE = 4'd0,
    RT_HIGH     = 4'd1,
    RT_LOW      = 4'd2,
    RT_HIGHLOW  = 4'd3,
    RT_HIGHADJ  = 4'd4,
    RT_MIPS_JMP = 4'd5,
    RT_SECTION  = 4'd6,
    RT_REL32    = 4'd7,
    RT_IMM64    = 4'd9,
    RT_DIR64    = 4'd10,
    RT_HIGH3ADJ = 4'd11
  } rtype_t;

  // Pending pair state.
  typedef enum logic [1:0] {
    PK_NONE    = 2'd0,
    PK_ADJ     = 2'd1,
    PK_3ADJ_P1 = 2'd2,
    PK_3ADJ_P2 = 2'd3
  } kind_t;

  localparam int unsigned TypeShift  = 12;
  localparam logic [11:0] OffsetMask = 12'hfff;
  localparam logic [31:0] RoundHalf  = 32'h0000_8000;
  localparam logic [31:0] JumpMask   = 32'h03ff_ffff;

  // One input word.
  typedef struct packed {
    logic        first_of_image;
    logic        block_end;
    logic [31:0] page_rva;
    logic [15:0] entry_word;
    logic [63:0] target_data;
  } item_t;

  // One result word.
  typedef struct packed {
    status_t     status;
    logic [31:0] write_rva;
    size_t       write_size;
    logic [63:0] write_data;
  } result_t;

  // State carried from one entry to the next.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] target_rva;
    logic [15:0] high_half;
    logic [15:0] first_param;
    logic        error_seen;
  } pend_t;

endpackage

// ===== design/ibrf_fixup.sv =====
module ibrf_fixup (
  input  ibrf_pkg::item_t   item,
  input  ibrf_pkg::pend_t   pend,
  input  logic [63:0]       load_delta,
  output ibrf_pkg::result_t res,
  output ibrf_pkg::pend_t   pend_nxt
);
  import ibrf_pkg::*;

  logic [31:0] d32;
  logic [31:0] t32;
  logic [31:0] rva;
  logic [3:0]  rtype;
  logic [31:0] p_sext;
  logic [31:0] adj_sum;
  logic [47:0] adj3_sum;
  logic [31:0] adj3_rnd;
  logic [31:0] high_sum;
  logic [31:0] low_sum;
  logic [31:0] jmp_sum;
  logic [63:0] dir_sum;

  // Datapath terms shared by the decode below.
  always_comb begin
    d32      = load_delta[31:0];
    t32      = item.target_data[31:0];
    rva      = item.page_rva + {20'd0, item.entry_word[11:0] & OffsetMask};
    rtype    = item.entry_word[15:TypeShift];
    p_sext   = {{16{item.entry_word[15]}}, item.entry_word};
    adj_sum  = {pend.high_half, 16'd0} + p_sext + d32 + RoundHalf;
    adj3_sum = {pend.high_half, 16'd0, pend.first_param}
             + {p_sext, 16'd0}
             + load_delta[47:0]
             + {16'd0, RoundHalf};
    adj3_rnd = adj3_sum[47:16] + RoundHalf;
    high_sum = {t32[15:0], 16'd0} + d32;
    low_sum  = t32 + d32;
    jmp_sum  = {t32[29:0] & JumpMask[29:0], 2'b00} + d32;
    dir_sum  = item.target_data + load_delta;
  end

  // Decode of one entry against the pending pair state.
  always_comb begin
    pend_nxt = pend;
    res      = '{status: ST_NOWRITE, write_rva: 32'd0, write_size: SZ_NONE,
                 write_data: 64'd0};
    if (item.first_of_image) begin
      pend_nxt.error_seen = 1'b0;
      pend_nxt.kind       = PK_NONE;
    end
    if (pend_nxt.error_seen) begin
      res.status = ST_DROP;
    end else begin
      unique case (pend_nxt.kind)
        PK_ADJ: begin
          pend_nxt.kind  = PK_NONE;
          res.status     = ST_PATCH;
          res.write_rva  = pend.target_rva;
          res.write_size = SZ_2B;
          res.write_data = {48'd0, adj_sum[31:16]};
        end
        PK_3ADJ_P1: begin
          if (item.block_end) begin
            pend_nxt.error_seen = 1'b1;
            pend_nxt.kind       = PK_NONE;
            res.status          = ST_TRUNC;
          end else begin
            pend_nxt.first_param = item.entry_word;
            pend_nxt.kind        = PK_3ADJ_P2;
          end
        end
        PK_3ADJ_P2: begin
          pend_nxt.kind  = PK_NONE;
          res.status     = ST_PATCH;
          res.write_rva  = pend.target_rva;
          res.write_size = SZ_2B;
          res.write_data = {48'd0, adj3_rnd[31:16]};
        end
        PK_NONE: begin
          unique case (rtype)
            RT_ABSOLUTE, RT_SECTION, RT_REL32, RT_IMM64: begin
              res.status = ST_NOWRITE;
            end
            RT_HIGH: begin
              res.status     = ST_PATCH;
              res.write_rva  = rva;
              res.write_size = SZ_2B;
              res.write_data = {48'd0, high_sum[31:16]};
            end
            RT_LOW: begin
              res.status     = ST_PATCH;
              res.write_rva  = rva;
              res.write_size = SZ_2B;
              res.write_data = {48'd0, low_sum[15:0]};
            end
            RT_HIGHLOW: begin
              res.status     = ST_PATCH;
              res.write_rva  = rva;
              res.write_size = SZ_4B;
              res.write_data = {32'd0, low_sum};
            end
            RT_MIPS_JMP: begin
              res.status     = ST_PATCH;
              res.write_rva  = rva;
              res.write_size = SZ_4B;
              res.write_data = {32'd0, (t32 & ~JumpMask)
                                       | ({6'd0, jmp_sum[27:2]} & JumpMask)};
            end
            RT_DIR64: begin
              res.status     = ST_PATCH;
              res.write_rva  = rva;
              res.write_size = SZ_8B;
              res.write_data = dir_sum;
            end
            RT_HIGHADJ, RT_HIGH3ADJ: begin
              if (item.block_end) begin
                pend_nxt.error_seen = 1'b1;
                pend_nxt.kind       = PK_NONE;
                res.status          = ST_TRUNC;
              end else begin
                pend_nxt.kind       = (rtype == RT_HIGHADJ) ? PK_ADJ : PK_3ADJ_P1;
                pend_nxt.target_rva = rva;
                pend_nxt.high_half  = t32[15:0];
              end
            end
            default: begin
              // Reserved type codes.
              pend_nxt.error_seen = 1'b1;
              pend_nxt.kind       = PK_NONE;
              res.status          = ST_ILLEGAL;
            end
          endcase
        end
        default: begin
          res.status = ST_NOWRITE;
        end
      endcase
    end
  end

endmodule

// ===== design/image_base_relocation_fixup.sv =====
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    first_of_image, block_end, page_rva,
//                                            entry_word, target_data
// out_     output     out_valid / out_stall  status, write_rva, write_size,
//                                            write_data
// cfg_     input      cfg_valid / cfg_ready  load_delta
//
// One entry word is accepted per cycle while in_stall is low; each word passes
// through the input register, the single decode and add stage and the result
// register, in that order. The pair state is updated as a word moves from
// the input register to the result register. Synchronous active-low reset
// clears the pipeline valids, the pair state and load_delta. A stall on the
// result side holds the result and, once the input register is full, raises
// in_stall in the same cycle.
module image_base_relocation_fixup (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_first_of_image,
  input  logic        in_block_end,
  input  logic [31:0] in_page_rva,
  input  logic [15:0] in_entry_word,
  input  logic [63:0] in_target_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_write_rva,
  output logic [1:0]  out_write_size,
  output logic [63:0] out_write_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_load_delta
);
  import ibrf_pkg::*;

  logic    s1_valid_r;
  logic    s1_valid_nxt;
  item_t   s1_item_r;
  logic    res_valid_r;
  logic    res_valid_nxt;
  result_t res_r;
  result_t res_nxt;
  pend_t   pend_r;
  pend_t   pend_nxt;
  logic [63:0] delta_r;
  logic    out_free;
  logic    advance;
  logic    in_take;

  // Handshake control for the two register stages.
  assign out_free  = !res_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    res_valid_nxt = res_valid_r;
    if (advance) begin
      res_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      res_valid_nxt = 1'b0;
    end
  end

  ibrf_fixup u_fixup (
    .item       (s1_item_r),
    .pend       (pend_r),
    .load_delta (delta_r),
    .res        (res_nxt),
    .pend_nxt   (pend_nxt)
  );

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      pend_r      <= '{kind: PK_NONE, target_rva: 32'd0, high_half: 16'd0,
                       first_param: 16'd0, error_seen: 1'b0};
      delta_r     <= 64'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      res_valid_r <= res_valid_nxt;
      if (advance) begin
        pend_r <= pend_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        delta_r <= cfg_load_delta;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= '{first_of_image: in_first_of_image, block_end: in_block_end,
                     page_rva: in_page_rva, entry_word: in_entry_word,
                     target_data: in_target_data};
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = res_valid_r;
  assign out_status     = res_r.status;
  assign out_write_rva  = res_r.write_rva;
  assign out_write_size = res_r.write_size;
  assign out_write_data = res_r.write_data;

endmodule

// ===== design/ibrf_checker.sv =====
module ibrf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_write_rva,
  input logic [1:0]  out_write_size,
  input logic [63:0] out_write_data
);
  import ibrf_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_write_rva) && $stable(out_write_size) && $stable(out_write_data))
    else $error("result word changed under stall");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Only patches carry an address, size or data.
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_PATCH |->
      out_write_size == SZ_NONE && out_write_rva == 32'd0 && out_write_data == 64'd0)
    else $error("non-patch result carries write fields");

  // Patch data fits its size.
  a_size_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_PATCH |->
      (out_write_size == SZ_2B && out_write_data[63:16] == 48'd0)
      || (out_write_size == SZ_4B && out_write_data[63:32] == 32'd0)
      || out_write_size == SZ_8B)
    else $error("patch size and data disagree");

endmodule

bind image_base_relocation_fixup ibrf_checker u_ibrf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_write_rva  (out_write_rva),
  .out_write_size (out_write_size),
  .out_write_data (out_write_data)
);

// ===== tb/sv/ibrf_tb_pkg.sv =====
`timescale 1ns / 1ps

package ibrf_tb_pkg;

  import ibrf_pkg::*;

  // Tracks the relocation state the block should hold and the patches it owes.
  class relocation_scoreboard;
    logic [63:0] delta;
    kind_t       pair_kind;
    logic [31:0] pair_rva;
    logic [15:0] pair_high;
    logic [15:0] pair_p1;
    bit          dropping;
    result_t     owed_patches[$];
    int unsigned faults;
    int unsigned live_entries;
    int unsigned tally[5];

    function new();
      delta = '0;
      pair_kind = PK_NONE;
      pair_rva = '0;
      pair_high = '0;
      pair_p1 = '0;
      dropping = 1'b0;
      faults = 0;
      live_entries = 0;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    // An error ends the image: nothing is written and the pair is abandoned.
    function result_t flag(status_t st);
      result_t res;
      res = '0;
      res.status = st;
      dropping = 1'b1;
      pair_kind = PK_NONE;
      return res;
    endfunction

    // Works out the write request that one entry word produces.
    function result_t fix_entry(item_t it);
      result_t     res;
      logic [31:0] d32;
      logic [31:0] rva;
      logic [31:0] t32;
      logic [31:0] r;
      logic [63:0] v;
      logic [15:0] w;
      logic [3:0]  code;
      res = '0;
      res.status = ST_NOWRITE;
      res.write_size = SZ_NONE;
      w = it.entry_word;
      d32 = delta[31:0];
      t32 = it.target_data[31:0];
      if (it.first_of_image) begin
        dropping = 1'b0;
        pair_kind = PK_NONE;
      end
      if (dropping) begin
        res.status = ST_DROP;
        return res;
      end

      // Parameter words of a pending adjusted pair.
      case (pair_kind)
        PK_ADJ: begin
          r = {pair_high, 16'h0000} + {{16{w[15]}}, w} + d32 + RoundHalf;
          pair_kind = PK_NONE;
          res = '{ST_PATCH, pair_rva, SZ_2B, {48'h0, r[31:16]}};
          return res;
        end
        PK_3ADJ_P1: begin
          if (it.block_end) return flag(ST_TRUNC);
          pair_p1 = w;
          pair_kind = PK_3ADJ_P2;
          return res;
        end
        PK_3ADJ_P2: begin
          v = {16'h0, pair_high, 32'h0} + ({{48{w[15]}}, w} << 16) + {48'h0, pair_p1};
          v = v + delta + RoundHalf;
          v = (v >> 16) + RoundHalf;
          pair_kind = PK_NONE;
          res = '{ST_PATCH, pair_rva, SZ_2B, {48'h0, v[31:16]}};
          return res;
        end
        default: ;
      endcase

      // A regular entry: type in the top nibble, page offset below it.
      rva = it.page_rva + {20'h0, w[11:0] & OffsetMask};
      code = 4'(w >> TypeShift);
      case (code)
        RT_ABSOLUTE, RT_SECTION, RT_REL32, RT_IMM64: ;
        RT_HIGH: begin
          r = {t32[15:0], 16'h0000} + d32;
          res = '{ST_PATCH, rva, SZ_2B, {48'h0, r[31:16]}};
        end
        RT_LOW: begin
          r = t32 + d32;
          res = '{ST_PATCH, rva, SZ_2B, {48'h0, r[15:0]}};
        end
        RT_HIGHLOW: begin
          r = t32 + d32;
          res = '{ST_PATCH, rva, SZ_4B, {32'h0, r}};
        end
        RT_MIPS_JMP: begin
          r = ((t32 & JumpMask) << 2) + d32;
          r = (t32 & ~JumpMask) | ((r >> 2) & JumpMask);
          res = '{ST_PATCH, rva, SZ_4B, {32'h0, r}};
        end
        RT_DIR64: res = '{ST_PATCH, rva, SZ_8B, it.target_data + delta};
        RT_HIGHADJ, RT_HIGH3ADJ: begin
          if (it.block_end) return flag(ST_TRUNC);
          pair_kind = (code == RT_HIGHADJ) ? PK_ADJ : PK_3ADJ_P1;
          pair_rva = rva;
          pair_high = t32[15:0];
        end
        default: return flag(ST_ILLEGAL);
      endcase
      return res;
    endfunction

    // Called for every word the block accepts on its input.
    function void note_entry(item_t it);
      result_t r;
      r = fix_entry(it);
      owed_patches.push_back(r);
      tally[r.status]++;
      if (r.status != ST_DROP) live_entries++;
    endfunction

    // Called for every word the block hands over on its result side.
    function void check_patch(result_t got);
      result_t want;
      if (owed_patches.size() == 0) begin
        faults++;
        $display("%0t: result with no entry waiting: status %0d rva %h data %h",
                 $time, got.status, got.write_rva, got.write_data);
        return;
      end
      want = owed_patches.pop_front();
      if (got.status !== want.status) begin
        faults++;
        $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
      end
      if (got.write_rva !== want.write_rva) begin
        faults++;
        $display("%0t: write_rva expected %h, actual %h", $time, want.write_rva,
                 got.write_rva);
      end
      if (got.write_size !== want.write_size) begin
        faults++;
        $display("%0t: write_size expected %0d, actual %0d", $time, want.write_size,
                 got.write_size);
      end
      if (got.write_data !== want.write_data) begin
        faults++;
        $display("%0t: write_data expected %h, actual %h", $time, want.write_data,
                 got.write_data);
      end
    endfunction

    function int owed();
      return owed_patches.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/image_base_relocation_fixup_tb.sv =====
`timescale 1ns / 1ps

module image_base_relocation_fixup_tb;

  import ibrf_pkg::*;
  import ibrf_tb_pkg::*;

  localparam int QuietLimit  = 500;
  localparam int RandomItems = 1500;
  localparam int Phases      = 8;

  // Type codes the block must reject.
  localparam logic [3:0] RT_RESERVED    = 4'd8;
  localparam logic [3:0] RT_FIRST_UNUSED = 4'd12;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_first_of_image = 1'b0;
  logic        in_block_end = 1'b0;
  logic [31:0] in_page_rva = '0;
  logic [15:0] in_entry_word = '0;
  logic [63:0] in_target_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_write_rva;
  logic [1:0]  out_write_size;
  logic [63:0] out_write_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_load_delta = '0;

  relocation_scoreboard sb = new();
  bit calm = 1'b0;
  bit image_broken = 1'b0;
  int settings = 0;
  int quiet_cycles = 0;

  image_base_relocation_fixup uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first_of_image(in_first_of_image),
    .in_block_end     (in_block_end),
    .in_page_rva      (in_page_rva),
    .in_entry_word    (in_entry_word),
    .in_target_data   (in_target_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_write_rva    (out_write_rva),
    .out_write_size   (out_write_size),
    .out_write_data   (out_write_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_load_delta   (cfg_load_delta)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Every accepted input word goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      sb.note_entry({in_first_of_image, in_block_end, in_page_rva, in_entry_word,
                     in_target_data});
  end

  // Every accepted result word is checked against the oldest owed patch.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_patch({out_status, out_write_rva, out_write_size, out_write_data});
  end

  // The run is stuck if no word moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("%0t: no word moved in %0d cycles", $time, QuietLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result-side back-pressure in short bursts, with calm stretches between.
  initial begin : stall_gen
    int n;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 30) == 0) begin
        n = $urandom_range(10, 40);
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic item_t mk(bit first, bit last, logic [31:0] page, logic [15:0] word,
                               logic [63:0] data);
    item_t it;
    it.first_of_image = first;
    it.block_end = last;
    it.page_rva = page;
    it.entry_word = word;
    it.target_data = data;
    return it;
  endfunction

  function automatic logic [63:0] target64();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [15:0] param16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] one_shot_type();
    case ($urandom_range(0, 9))
      0: return RT_ABSOLUTE;
      1: return RT_SECTION;
      2: return RT_REL32;
      3: return RT_IMM64;
      4: return RT_HIGH;
      5: return RT_LOW;
      6: return RT_HIGHLOW;
      7: return RT_MIPS_JMP;
      default: return RT_DIR64;
    endcase
  endfunction

  function automatic logic [3:0] bad_type();
    if ($urandom_range(0, 4) == 0) return RT_RESERVED;
    return RT_FIRST_UNUSED + 4'($urandom_range(0, 3));
  endfunction

  // Drives one input word, after an optional gap, and waits until it is taken.
  // Called at a rising edge; returns at the edge that accepts the word.
  task automatic push_entry(item_t it);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_of_image <= it.first_of_image;
    in_block_end <= it.block_end;
    in_page_rva <= it.page_rva;
    in_entry_word <= it.entry_word;
    in_target_data <= it.target_data;
    do @(posedge clk); while (in_stall);
  endtask

  // Holds the input back until every owed result has come out.
  task automatic await_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.owed() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_delta(logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_load_delta <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.delta = value;
    settings++;
  endtask

  // Field extremes, every type, pairs, cut-off pairs, errors and image restarts.
  task automatic directed_entries();
    logic [31:0] pg;
    pg = 32'h0001_2000;
    push_entry(mk(1, 0, pg, {RT_ABSOLUTE, 12'h000}, '0));
    push_entry(mk(0, 0, pg, {RT_HIGH, 12'hfff}, '1));
    push_entry(mk(0, 0, pg, {RT_LOW, 12'h001}, 64'h0000_0000_0000_8001));
    push_entry(mk(0, 0, 32'hffff_ffff, {RT_HIGHLOW, 12'hfff}, 64'h0123_4567_89ab_cdef));
    push_entry(mk(0, 0, pg, {RT_MIPS_JMP, 12'h800}, 64'hfc00_0000_ffff_ffff));
    push_entry(mk(0, 0, pg, {RT_DIR64, 12'h008}, '1));
    push_entry(mk(0, 0, pg, {RT_SECTION, 12'h010}, '1));
    push_entry(mk(0, 0, pg, {RT_REL32, 12'h020}, '1));
    push_entry(mk(0, 0, pg, {RT_IMM64, 12'h030}, '1));
    push_entry(mk(0, 0, pg, {RT_HIGHADJ, 12'h040}, 64'h0000_0000_0000_7fff));
    push_entry(mk(0, 0, '1, 16'h8000, '1));
    push_entry(mk(0, 0, pg, {RT_HIGH3ADJ, 12'h050}, 64'h0000_0000_0000_ffff));
    push_entry(mk(0, 0, '0, 16'hffff, '0));
    push_entry(mk(0, 1, '1, 16'h8000, '1));
    // A parameter that closes its block is still a complete pair.
    push_entry(mk(1, 0, '0, {RT_HIGHADJ, 12'h060}, 64'h0000_0000_0000_8000));
    push_entry(mk(0, 1, '0, 16'h7fff, '0));
    // Pairs cut off by the end of the block, then dropped words.
    push_entry(mk(0, 1, pg, {RT_HIGHADJ, 12'h070}, '1));
    push_entry(mk(0, 0, pg, {RT_LOW, 12'h080}, '1));
    push_entry(mk(1, 0, pg, {RT_HIGH3ADJ, 12'h090}, '1));
    push_entry(mk(0, 1, pg, 16'h1234, '1));
    // Reserved and unused type codes.
    push_entry(mk(1, 0, pg, {RT_RESERVED, 12'h0a0}, '1));
    push_entry(mk(0, 0, pg, {RT_HIGHLOW, 12'h0b0}, '1));
    push_entry(mk(1, 0, pg, {4'hf, 12'h0c0}, '1));
    // A new image abandons a pair that is still waiting for its parameter.
    push_entry(mk(1, 0, pg, {RT_HIGHADJ, 12'h0d0}, '1));
    push_entry(mk(1, 0, pg, {RT_HIGHLOW, 12'h0e0}, 64'h0000_0000_7fff_ffff));
    push_entry(mk(1, 1, '0, {RT_HIGH, 12'h000}, '0));
  endtask

  // One relocation block of well-formed groups, now and then broken or noisy.
  task automatic send_block();
    item_t       blk[$];
    logic [31:0] page;
    int          len;
    int          pick;
    bit          cut;
    bit          fresh;
    page = $urandom;
    len = $urandom_range(1, 8);
    cut = 1'b0;
    fresh = image_broken ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0);
    if (fresh) image_broken = 1'b0;
    while (blk.size() < len && !cut) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        blk.push_back(mk(0, 0, page, {bad_type(), 12'($urandom)}, target64()));
        image_broken = 1'b1;
      end else if (pick < 6) begin
        // Pair entry cut off at the block end before all its parameters arrive.
        blk.push_back(mk(0, 0, page, {(pick == 5) ? RT_HIGH3ADJ : RT_HIGHADJ,
                                      12'($urandom)}, target64()));
        if (pick == 5 && $urandom_range(0, 1) == 1)
          blk.push_back(mk(0, 0, $urandom, param16(), target64()));
        cut = 1'b1;
        image_broken = 1'b1;
      end else if (pick < 22) begin
        blk.push_back(mk(0, 0, page, {RT_HIGHADJ, 12'($urandom)}, target64()));
        blk.push_back(mk(0, 0, $urandom, param16(), target64()));
      end else if (pick < 36) begin
        blk.push_back(mk(0, 0, page, {RT_HIGH3ADJ, 12'($urandom)}, target64()));
        blk.push_back(mk(0, 0, $urandom, param16(), target64()));
        blk.push_back(mk(0, 0, $urandom, param16(), target64()));
      end else begin
        blk.push_back(mk(0, 0, page, {one_shot_type(), 12'($urandom)}, target64()));
      end
    end
    // Rare image restarts in mid-block, including on parameter words.
    foreach (blk[i])
      if ($urandom_range(0, 49) == 0) blk[i].first_of_image = 1'b1;
    blk[0].first_of_image |= fresh;
    blk[blk.size() - 1].block_end = 1'b1;
    foreach (blk[i]) push_entry(blk[i]);
  endtask

  function automatic logic [63:0] phase_delta(int k);
    case (k)
      0: return 64'h0;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'hffff_ffff_ffff_ffff;
      4: return 64'h0000_0000_0000_8000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Reset, directed words, then random blocks under a series of load deltas.
  initial begin : main_flow
    int k;
    int goal;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_delta(64'h0000_0001_8000_7fff);
    directed_entries();
    await_idle();
    for (k = 0; k < Phases; k++) begin
      calm = (k == Phases - 1);
      write_delta(phase_delta(k));
      goal = sb.live_entries + RandomItems / Phases;
      while (sb.live_entries < goal) send_block();
      await_idle();
    end
    repeat (10) @(posedge clk);
    $display("Covered %0d live entries under %0d load deltas: %0d patches, %0d no-write,",
             sb.live_entries, settings, sb.tally[ST_PATCH], sb.tally[ST_NOWRITE]);
    $display("%0d illegal types, %0d cut-off pairs, %0d dropped; %0d results still owed.",
             sb.tally[ST_ILLEGAL], sb.tally[ST_TRUNC], sb.tally[ST_DROP], sb.owed());
    if (sb.faults == 0 && sb.owed() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ibrf_pkg.sv
design/ibrf_fixup.sv
design/image_base_relocation_fixup.sv
design/ibrf_checker.sv
tb/sv/ibrf_tb_pkg.sv
tb/sv/image_base_relocation_fixup_tb.sv
